FILE: hw/rtl/maximal_frequent_itemset_miner_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the maximal frequent itemset miner
// Every assertion is sampled on the rising edge of clk_i and is held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MAXIMAL_FREQUENT_ITEMSET_MINER_TOP_ASSERT_SVH
`define MAXIMAL_FREQUENT_ITEMSET_MINER_TOP_ASSERT_SVH

// A property that must hold in the same cycle.
`define MFIM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mfim: assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define MFIM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mfim: assertion failed");

`endif

FILE: hw/rtl/mfim_pkg.sv
// ----------------------------------------------------------------------------
// mfim_pkg
// Types and constants shared by the maximal frequent itemset miner.
// ----------------------------------------------------------------------------
package mfim_pkg;

  localparam int unsigned NUM_ITEMS_DEF = 6;
  localparam int unsigned MAX_TRANS_DEF = 256;

  // At most this many maximal itemsets are reported per mine command.
  localparam int unsigned FOUND_DEPTH = 20;
  localparam int unsigned FOUND_CNT_W = $clog2(FOUND_DEPTH + 1);
  localparam int unsigned FOUND_IDX_W = $clog2(FOUND_DEPTH);

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned TRANS_IDX_W = 8;
  localparam int unsigned ITEM_CODE_W = 3;

  localparam int unsigned MIN_SUP_W = 9;
  localparam logic [MIN_SUP_W-1:0] MIN_SUP_RESET = 9'd3;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index, taken from the word address bits of paddr.
  localparam logic [PADDR_W-3:0] REG_MIN_SUPPORT = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_MINE  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

endpackage

FILE: hw/rtl/mfim_if.sv
// ----------------------------------------------------------------------------
// mfim stream interfaces
// Valid/ready channels for commands into the miner and itemsets out of it.
// ----------------------------------------------------------------------------
interface mfim_in_if import mfim_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [TRANS_IDX_W-1:0] trans_index;
  logic [ITEM_CODE_W-1:0] item_code;

  modport source (output valid, mode, trans_index, item_code, input ready);
  modport sink   (input valid, mode, trans_index, item_code, output ready);
endinterface

interface mfim_out_if import mfim_pkg::*; #(
  parameter int unsigned NUM_ITEMS = NUM_ITEMS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [NUM_ITEMS-1:0] itemset;
  logic                 none_found;
  logic                 last;

  modport source (output valid, itemset, none_found, last, input ready);
  modport sink   (input valid, itemset, none_found, last, output ready);
endinterface

FILE: hw/rtl/mfim_ram.sv
// ----------------------------------------------------------------------------
// mfim_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfim_ram import mfim_pkg::*; #(
  parameter int unsigned WIDTH = NUM_ITEMS_DEF,
  parameter int unsigned DEPTH = MAX_TRANS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/maximal_frequent_itemset_miner_top.sv
// ----------------------------------------------------------------------------
// maximal_frequent_itemset_miner_top
// Per-transaction item masks held in RAM; mining reports maximal frequent sets.
// ----------------------------------------------------------------------------
// An add command sets one item bit in a transaction's mask with a read and a
// write of the mask RAM, and no other command is accepted until the write is
// done. A clear command, and the clearing pass that follows reset, write zero
// to every RAM entry, one per cycle, and no command is accepted until the pass
// ends; configuration writes are taken at any time.
// A mine command tests the nonzero itemsets from the largest mask down until
// all are tested or FOUND_DEPTH sets are found; each test reads the whole RAM
// through its single read port, and the mine can be held up while the output
// side stalls. Results leave through an output register, the last one flagged,
// and a single result with none_found is sent when no itemset reaches min_support.
// ----------------------------------------------------------------------------
`include "maximal_frequent_itemset_miner_top_assert.svh"

module maximal_frequent_itemset_miner_top import mfim_pkg::*; #(
  parameter int unsigned NUM_ITEMS = NUM_ITEMS_DEF,
  parameter int unsigned MAX_TRANS = MAX_TRANS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mfim_in_if.sink            in_i,
  mfim_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW   = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
  localparam int unsigned CW   = $clog2(MAX_TRANS + 1);
  localparam int unsigned CMPW = (CW > MIN_SUP_W) ? CW : MIN_SUP_W;
  localparam logic [NUM_ITEMS-1:0] SET_ALL = {NUM_ITEMS{1'b1}};
  localparam logic [NUM_ITEMS-1:0] SET_ONE = NUM_ITEMS'(1);
  localparam logic [AW-1:0]        T_LAST  = AW'(MAX_TRANS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_CLEAR,
    ST_COUNT,
    ST_EVAL,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          t_q, t_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   dv_q, dv_d;
  logic [NUM_ITEMS-1:0]   set_q, set_d;
  logic [AW-1:0]          add_addr_q, add_addr_d;
  logic [NUM_ITEMS-1:0]   add_bit_q, add_bit_d;
  logic [FOUND_CNT_W-1:0] found_cnt_q, found_cnt_d;
  logic [NUM_ITEMS-1:0]   pend_q, pend_d;
  logic                   pend_vld_q, pend_vld_d;
  logic                   out_vld_q, out_vld_d;
  logic [NUM_ITEMS-1:0]   out_set_q, out_set_d;
  logic                   out_none_q, out_none_d;
  logic                   out_last_q, out_last_d;
  logic [MIN_SUP_W-1:0]   min_sup_q, min_sup_d;
  logic [NUM_ITEMS-1:0]   found_q [FOUND_DEPTH];

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [NUM_ITEMS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [NUM_ITEMS-1:0] ram_rdata;

  logic                 in_acc;
  logic                 idx_ok;
  logic                 code_ok;
  logic [NUM_ITEMS-1:0] item_bit;
  logic                 t_last;
  logic                 hit;
  logic [CW-1:0]        cnt_sum;
  logic [MIN_SUP_W-1:0] need;
  logic                 frequent;
  logic                 covered;
  logic                 out_free;
  logic                 found_we;
  logic                 cfg_we;

  mfim_ram #(
    .WIDTH (NUM_ITEMS),
    .DEPTH (MAX_TRANS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_MIN_SUPPORT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_MIN_SUPPORT) ? PDATA_W'(min_sup_q) : '0;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign idx_ok     = (32'(in_i.trans_index) < MAX_TRANS);
  assign code_ok    = (in_i.item_code != '0) && (32'(in_i.item_code) <= NUM_ITEMS);
  assign item_bit   = SET_ONE << (in_i.item_code - ITEM_CODE_W'(1));

  assign t_last   = (t_q == T_LAST);
  assign hit      = ((ram_rdata & set_q) == set_q);
  assign cnt_sum  = cnt_q + CW'(dv_q && hit);
  // A minimum support of zero behaves as one.
  assign need     = (min_sup_q == '0) ? MIN_SUP_W'(1) : min_sup_q;
  assign frequent = (CMPW'(cnt_q) >= CMPW'(need));
  assign out_free = !out_vld_q || out_o.ready;

  // The candidate is covered when it is a subset of any set already found.
  always_comb begin
    covered = 1'b0;
    for (int j = 0; j < FOUND_DEPTH; j++) begin
      if ((FOUND_CNT_W'(j) < found_cnt_q) && ((found_q[j] | set_q) == found_q[j])) begin
        covered = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    cnt_d       = cnt_q;
    dv_d        = dv_q;
    set_d       = set_q;
    add_addr_d  = add_addr_q;
    add_bit_d   = add_bit_q;
    found_cnt_d = found_cnt_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_set_d   = out_set_q;
    out_none_d  = out_none_q;
    out_last_d  = out_last_q;
    min_sup_d   = cfg_we ? pwdata[MIN_SUP_W-1:0] : min_sup_q;
    found_we    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = t_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = t_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_i.mode)
            MODE_ADD: begin
              if (idx_ok && code_ok) begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(in_i.trans_index);
                add_addr_d = AW'(in_i.trans_index);
                add_bit_d  = item_bit;
                state_d    = ST_ADD_WR;
              end
            end
            MODE_MINE: begin
              set_d       = SET_ALL;
              found_cnt_d = '0;
              pend_vld_d  = 1'b0;
              t_d         = '0;
              cnt_d       = '0;
              dv_d        = 1'b0;
              state_d     = ST_COUNT;
            end
            MODE_CLEAR: begin
              t_d     = '0;
              state_d = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = add_addr_q;
        ram_wdata = ram_rdata | add_bit_q;
        state_d   = ST_IDLE;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = t_q;
        t_d       = t_q + AW'(1);
        if (t_last) begin
          t_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_COUNT: begin
        // Read data arrives in the cycle after its address, flagged by dv_q.
        ram_re = 1'b1;
        dv_d   = 1'b1;
        cnt_d  = cnt_sum;
        t_d    = t_q + AW'(1);
        if (t_last) begin
          t_d     = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cnt_d   = cnt_sum;
        dv_d    = 1'b0;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (frequent && !covered) begin
          // The previous find goes out only now that we know it is not last.
          if (!pend_vld_q || out_free) begin
            found_we    = 1'b1;
            found_cnt_d = found_cnt_q + FOUND_CNT_W'(1);
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_set_d  = pend_q;
              out_none_d = 1'b0;
              out_last_d = 1'b0;
            end
            pend_d     = set_q;
            pend_vld_d = 1'b1;
            if ((set_q == SET_ONE) || (found_cnt_q == FOUND_CNT_W'(FOUND_DEPTH - 1))) begin
              state_d = ST_FINISH;
            end else begin
              set_d   = set_q - SET_ONE;
              cnt_d   = '0;
              state_d = ST_COUNT;
            end
          end
        end else if (set_q == SET_ONE) begin
          state_d = ST_FINISH;
        end else begin
          set_d   = set_q - SET_ONE;
          cnt_d   = '0;
          state_d = ST_COUNT;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_set_d  = pend_vld_q ? pend_q : '0;
          out_none_d = !pend_vld_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      t_q         <= '0;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      set_q       <= '0;
      add_addr_q  <= '0;
      add_bit_q   <= '0;
      found_cnt_q <= '0;
      pend_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      out_set_q   <= '0;
      out_none_q  <= 1'b0;
      out_last_q  <= 1'b0;
      min_sup_q   <= MIN_SUP_RESET;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      set_q       <= set_d;
      add_addr_q  <= add_addr_d;
      add_bit_q   <= add_bit_d;
      found_cnt_q <= found_cnt_d;
      pend_q      <= pend_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
      out_set_q   <= out_set_d;
      out_none_q  <= out_none_d;
      out_last_q  <= out_last_d;
      min_sup_q   <= min_sup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (found_we) begin
      found_q[found_cnt_q[FOUND_IDX_W-1:0]] <= set_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.itemset    = out_set_q;
  assign out_o.none_found = out_none_q;
  assign out_o.last       = out_last_q;

  `MFIM_ASSERT(a_found_bounded, found_cnt_q <= FOUND_CNT_W'(FOUND_DEPTH))
  `MFIM_ASSERT(a_pend_has_find, !pend_vld_q || (found_cnt_q != '0))
  `MFIM_ASSERT(a_none_is_last, !out_vld_q || !out_none_q || (out_last_q && out_set_q == '0))
  `MFIM_ASSERT(a_ram_write_states, !ram_we || state_q == ST_ADD_WR || state_q == ST_CLEAR)
  `MFIM_ASSERT_NEXT(a_mine_starts, in_acc && in_i.mode == MODE_MINE, state_q == ST_COUNT)

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the maximal frequent itemset miner. Add, clear and
// mine commands are streamed in bursts while the output side stalls on its
// own pattern. Each accepted mine is predicted from a local copy of the
// transaction masks, and every returned itemset is checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfim_pkg::*;

  localparam int unsigned N_ITEMS = NUM_ITEMS_DEF;
  localparam int unsigned N_TRANS = MAX_TRANS_DEF;
  localparam int          SET_MAX = (1 << N_ITEMS) - 1;

  localparam logic [MODE_W-1:0]  MODE_SPARE   = 2'd3;
  localparam logic [PADDR_W-1:0] MIN_SUP_ADDR = {REG_MIN_SUPPORT, 2'b00};

  // Long enough to cover a clear pass once the last result is in.
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 20000;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [TRANS_IDX_W-1:0] trans_index;
    logic [ITEM_CODE_W-1:0] item_code;
  } cmd_t;

  typedef struct packed {
    logic [N_ITEMS-1:0] itemset;
    logic               none_found;
    logic               last;
  } mfs_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_style_e;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mfim_in_if                         in_if ();
  mfim_out_if #(.NUM_ITEMS(N_ITEMS)) out_if ();

  maximal_frequent_itemset_miner_top #(
    .NUM_ITEMS(N_ITEMS),
    .MAX_TRANS(N_TRANS)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Local copy of the block's state.
  logic [N_ITEMS-1:0]   basket_mask [N_TRANS];
  logic [MIN_SUP_W-1:0] min_sup_model;

  cmd_t cmd_q[$];
  mfs_t mfs_exp_q[$];

  int mismatches = 0;

  cmd_t      drv_cmd;
  cmd_t      seen_cmd;
  mfs_t      exp_r;
  logic      in_taken     = 1'b0;
  int        burst_left   = 1;
  int        gap_left     = 0;
  int        rx_hold_left = 0;
  int        rx_span      = 0;
  rx_style_e rx_style     = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL maximal_frequent_itemset_miner_top");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_cmd(input cmd_t c);
    logic [N_ITEMS-1:0] found [FOUND_DEPTH];
    logic [N_ITEMS-1:0] cand;
    int                 nf;
    int                 sup;
    int                 need;
    bit                 covered;
    mfs_t               r;
    case (c.mode)
      MODE_ADD: begin
        // The index field cannot leave the store, so only the code is screened.
        if (c.item_code >= 1 && c.item_code <= N_ITEMS)
          basket_mask[c.trans_index][c.item_code - 1] = 1'b1;
      end
      MODE_CLEAR: begin
        for (int t = 0; t < N_TRANS; t++) basket_mask[t] = '0;
      end
      MODE_MINE: begin
        nf   = 0;
        need = (min_sup_model == 0) ? 1 : int'(min_sup_model);
        for (int v = SET_MAX; v >= 1 && nf < FOUND_DEPTH; v--) begin
          cand = N_ITEMS'(v);
          sup  = 0;
          for (int t = 0; t < N_TRANS; t++)
            if ((basket_mask[t] & cand) == cand) sup++;
          if (sup >= need) begin
            covered = 1'b0;
            for (int j = 0; j < nf; j++)
              if ((found[j] | cand) == found[j]) covered = 1'b1;
            if (!covered) begin
              found[nf] = cand;
              nf++;
            end
          end
        end
        if (nf == 0) begin
          r.itemset    = '0;
          r.none_found = 1'b1;
          r.last       = 1'b1;
          mfs_exp_q.push_back(r);
        end else begin
          for (int k = 0; k < nf; k++) begin
            r.itemset    = found[k];
            r.none_found = 1'b0;
            r.last       = (k == nf - 1);
            mfs_exp_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [MODE_W-1:0] m, input int idx, input int code);
    cmd_t c;
    c.mode        = m;
    c.trans_index = TRANS_IDX_W'(idx);
    c.item_code   = ITEM_CODE_W'(code);
    cmd_q.push_back(c);
  endtask

  task automatic queue_mine();
    queue_cmd(MODE_MINE, $urandom_range(0, 255), $urandom_range(0, 7));
  endtask

  task automatic queue_clear();
    queue_cmd(MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 7));
  endtask

  // Returns once every command is taken and every result is in, plus a margin.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_if.valid || mfs_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_min_support(input int value);
    logic [PDATA_W-1:0] wd;
    logic [PDATA_W-1:0] rd;
    wd = $urandom();
    wd[MIN_SUP_W-1:0] = MIN_SUP_W'(value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MIN_SUP_ADDR;
    pwdata  <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    min_sup_model = wd[MIN_SUP_W-1:0];
    // Read the register back right away.
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDATA_W'(min_sup_model))
      report_mismatch($sformatf("min_support read %0h, expected %0h", rd, min_sup_model));
  endtask

  // Command driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (cmd_q.size() != 0) begin
        drv_cmd = cmd_q.pop_front();
        in_if.mode        <= drv_cmd.mode;
        in_if.trans_index <= drv_cmd.trans_index;
        in_if.item_code   <= drv_cmd.item_code;
        in_if.valid       <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: a stall pattern that changes every so often, plus one
  // long hold-off when requested.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      if (rx_span == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        rx_span  = $urandom_range(16, 200);
      end else begin
        rx_span--;
      end
      case (rx_style)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 5) == 0);
        default:   out_if.ready <= ~out_if.ready;
      endcase
    end
  end

  // Monitor: predicts on each accepted command and checks each result.
  always @(posedge clk) begin
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      seen_cmd = {in_if.mode, in_if.trans_index, in_if.item_code};
      predict_cmd(seen_cmd);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (mfs_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, itemset %0h", out_if.itemset));
      end else begin
        exp_r = mfs_exp_q.pop_front();
        if (out_if.itemset !== exp_r.itemset)
          report_mismatch($sformatf("itemset %0h, expected %0h", out_if.itemset,
                                    exp_r.itemset));
        if (out_if.none_found !== exp_r.none_found)
          report_mismatch($sformatf("none_found %0b, expected %0b", out_if.none_found,
                                    exp_r.none_found));
        if (out_if.last !== exp_r.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_if.last, exp_r.last));
      end
    end
  end

  initial begin
    int trip [64];
    int ntrip;
    int tmp;
    int j;
    int base;
    int span;
    int n_add;
    int ep;

    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_ADD;
    in_if.trans_index = '0;
    in_if.item_code   = '0;
    out_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    min_sup_model     = MIN_SUP_RESET;
    for (int t = 0; t < N_TRANS; t++) basket_mask[t] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Mining an empty store at the reset threshold finds nothing.
    queue_mine();
    queue_cmd(MODE_ADD, 0, 1);
    queue_cmd(MODE_ADD, 255, 6);
    queue_cmd(MODE_ADD, 255, 1);
    queue_cmd(MODE_ADD, 0, 1);
    queue_cmd(MODE_ADD, 128, 0);
    queue_cmd(MODE_ADD, 127, 7);
    queue_cmd(MODE_SPARE, 255, 7);
    queue_cmd(MODE_ADD, 1, 1);
    queue_cmd(MODE_ADD, 2, 1);
    queue_mine();
    wait_idle();
    // A zero threshold behaves as one.
    set_min_support(0);
    queue_mine();
    wait_idle();
    set_min_support(1);
    queue_cmd(MODE_ADD, 170, 2);
    queue_cmd(MODE_ADD, 85, 4);
    queue_clear();
    queue_mine();

    // Every three-item set in a transaction of its own gives the most results.
    wait_idle();
    set_min_support(1);
    queue_clear();
    ntrip = 0;
    for (int v = 1; v <= SET_MAX; v++) begin
      if ($countones(v) == 3) begin
        trip[ntrip] = v;
        ntrip++;
      end
    end
    for (int k = ntrip - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = trip[k];
      trip[k] = trip[j];
      trip[j] = tmp;
    end
    base = $urandom_range(0, 255);
    for (int k = 0; k < ntrip; k++)
      for (int b = 0; b < N_ITEMS; b++)
        if (trip[k][b]) queue_cmd(MODE_ADD, base + k, b + 1);
    queue_mine();

    // The largest thresholds cannot be met by this store.
    wait_idle();
    set_min_support(256);
    queue_mine();
    wait_idle();
    set_min_support(511);
    queue_mine();

    // Hold the output off while commands keep coming, so the input backs up.
    wait_idle();
    set_min_support(2);
    rx_hold_left = HOLD_CYCLES;
    base = $urandom_range(0, 255);
    for (int k = 0; k < 8; k++) queue_cmd(MODE_ADD, base + $urandom_range(0, 5),
                                          $urandom_range(1, 6));
    queue_mine();
    for (int k = 0; k < 12; k++) queue_cmd(MODE_ADD, base + $urandom_range(0, 5),
                                           $urandom_range(1, 6));
    queue_mine();

    // Random phases: a threshold, an optional clear, a batch of adds, a mine.
    ep = 0;
    while (ep < 5) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       set_min_support(0);
        1:       set_min_support(1);
        2:       set_min_support(2);
        3, 4:    set_min_support($urandom_range(3, 6));
        5:       set_min_support($urandom_range(7, 40));
        6:       set_min_support(256);
        default: set_min_support($urandom_range(1, 511));
      endcase
      if ($urandom_range(0, 2) == 0) queue_clear();
      n_add = $urandom_range(3, 12);
      base  = $urandom_range(0, 255);
      span  = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 12);
      for (int k = 0; k < n_add; k++) begin
        case ($urandom_range(0, 15))
          0:       queue_cmd(MODE_ADD, $urandom_range(0, 255),
                             ($urandom_range(0, 1) == 0) ? 0 : 7);
          1:       queue_cmd(MODE_SPARE, $urandom_range(0, 255), $urandom_range(0, 7));
          default: queue_cmd(MODE_ADD, base + $urandom_range(0, span), $urandom_range(1, 6));
        endcase
      end
      queue_mine();
      ep++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS maximal_frequent_itemset_miner_top");
    end else begin
      $display("FAIL maximal_frequent_itemset_miner_top");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mfim_pkg.sv
hw/rtl/mfim_if.sv
hw/rtl/mfim_ram.sv
hw/rtl/maximal_frequent_itemset_miner_top.sv
sim/tb.sv
